@@ rtl/core/rbi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and control store for the 2D rigid body integrator.
package rbi_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int PC_W       = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KINEMATIC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_DAMPING = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_DAMPING = 2'd3;

    localparam logic [2:0] KIND_FORCE     = 3'd0;
    localparam logic [2:0] KIND_IMPULSE   = 3'd1;
    localparam logic [2:0] KIND_TORQUE    = 3'd2;
    localparam logic [2:0] KIND_ANG_IMP   = 3'd3;
    localparam logic [2:0] KIND_INTEG_VEL = 3'd4;
    localparam logic [2:0] KIND_INTEG_POS = 3'd5;
    localparam logic [2:0] KIND_CLEAR     = 3'd6;
    localparam logic [2:0] KIND_LOAD_POSE = 3'd7;

    localparam logic [CFG_DATA_W-1:0] INV_MASS_RESET = 31'd65536;
    localparam logic signed [31:0]    DEG_PER_RAD    = 32'sd3754937;
    localparam logic signed [31:0]    RECIP_TEN      = 32'sd1717986919;
    localparam logic signed [47:0]    ONE_Q16        = 48'sd65536;
    localparam logic signed [31:0]    SPIN_MIN       = 32'sd7;

    localparam logic [PC_W-1:0] PC_FORCE     = 6'd0;
    localparam logic [PC_W-1:0] PC_IMPULSE   = 6'd2;
    localparam logic [PC_W-1:0] PC_TORQUE    = 6'd6;
    localparam logic [PC_W-1:0] PC_ANG_IMP   = 6'd7;
    localparam logic [PC_W-1:0] PC_INTEG_VEL = 6'd12;
    localparam logic [PC_W-1:0] PC_INTEG_POS = 6'd26;
    localparam logic [PC_W-1:0] PC_CLEAR     = 6'd34;
    localparam logic [PC_W-1:0] PC_LOAD_POSE = 6'd35;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] val_a;
        logic signed [31:0] val_b;
        logic signed [31:0] val_c;
        logic [19:0]        step_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin_rate;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading_deg;
    } out_item_t;

    typedef enum logic [3:0] {
        A_FX, A_FY, A_TQ, A_VX, A_VY, A_W, A_TX, A_TY, A_TW,
        A_INA, A_INB, A_INVM, A_LDAMP, A_ADAMP, A_ANG
    } a_sel_t;

    typedef enum logic [2:0] {
        B_INVM, B_II, B_DT, B_FL, B_FA, B_DEG, B_RECIP
    } b_sel_t;

    typedef enum logic [4:0] {
        WB_NONE, WB_FX_IN, WB_FY_IN, WB_TQ_IN,
        WB_VX_ADD, WB_VY_ADD, WB_W_ADD,
        WB_VX_SET, WB_VY_SET, WB_W_SET,
        WB_TX_SET, WB_TY_SET, WB_TW_SET,
        WB_PX_ADD, WB_PY_ADD, WB_HD_ADD,
        WB_FL, WB_FA, WB_ANG, WB_II, WB_CLR, WB_LOAD
    } wb_t;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_DONE, SEQ_DONE_IF_SLOW
    } seq_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        wb_t    wb;
        seq_t   seq;
    } ctrl_t;

    function automatic ctrl_t cw(input a_sel_t a, input b_sel_t b, input wb_t w,
                                 input seq_t s);
        cw = '{a_sel: a, b_sel: b, wb: w, seq: s};
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] kind);
        logic [PC_W-1:0] pc;
        unique case (kind)
            KIND_FORCE:     pc = PC_FORCE;
            KIND_IMPULSE:   pc = PC_IMPULSE;
            KIND_TORQUE:    pc = PC_TORQUE;
            KIND_ANG_IMP:   pc = PC_ANG_IMP;
            KIND_INTEG_VEL: pc = PC_INTEG_VEL;
            KIND_INTEG_POS: pc = PC_INTEG_POS;
            KIND_CLEAR:     pc = PC_CLEAR;
            default:        pc = PC_LOAD_POSE;
        endcase
        return pc;
    endfunction

    // Products register in prod_reg, then round into rnd_reg for writeback.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        unique case (pc)
            6'd0:  c = cw(A_VX,    B_DT,    WB_FX_IN,  SEQ_NEXT);
            6'd1:  c = cw(A_VX,    B_DT,    WB_FY_IN,  SEQ_DONE);
            6'd2:  c = cw(A_INA,   B_INVM,  WB_NONE,   SEQ_NEXT);
            6'd3:  c = cw(A_INB,   B_INVM,  WB_NONE,   SEQ_NEXT);
            6'd4:  c = cw(A_VX,    B_DT,    WB_VX_ADD, SEQ_NEXT);
            6'd5:  c = cw(A_VX,    B_DT,    WB_VY_ADD, SEQ_DONE);
            6'd6:  c = cw(A_VX,    B_DT,    WB_TQ_IN,  SEQ_DONE);
            6'd7:  c = cw(A_INVM,  B_RECIP, WB_NONE,   SEQ_NEXT);
            6'd8:  c = cw(A_VX,    B_DT,    WB_II,     SEQ_NEXT);
            6'd9:  c = cw(A_INA,   B_II,    WB_NONE,   SEQ_NEXT);
            6'd10: c = cw(A_VX,    B_DT,    WB_NONE,   SEQ_NEXT);
            6'd11: c = cw(A_VX,    B_DT,    WB_W_ADD,  SEQ_DONE);
            6'd12: c = cw(A_INVM,  B_RECIP, WB_NONE,   SEQ_NEXT);
            6'd13: c = cw(A_FX,    B_INVM,  WB_II,     SEQ_NEXT);
            6'd14: c = cw(A_FY,    B_INVM,  WB_NONE,   SEQ_NEXT);
            6'd15: c = cw(A_TQ,    B_II,    WB_TX_SET, SEQ_NEXT);
            6'd16: c = cw(A_LDAMP, B_DT,    WB_TY_SET, SEQ_NEXT);
            6'd17: c = cw(A_ADAMP, B_DT,    WB_TW_SET, SEQ_NEXT);
            6'd18: c = cw(A_TX,    B_DT,    WB_FL,     SEQ_NEXT);
            6'd19: c = cw(A_TY,    B_DT,    WB_FA,     SEQ_NEXT);
            6'd20: c = cw(A_TW,    B_DT,    WB_VX_ADD, SEQ_NEXT);
            6'd21: c = cw(A_VX,    B_FL,    WB_VY_ADD, SEQ_NEXT);
            6'd22: c = cw(A_VY,    B_FL,    WB_W_ADD,  SEQ_NEXT);
            6'd23: c = cw(A_W,     B_FA,    WB_VX_SET, SEQ_NEXT);
            6'd24: c = cw(A_VX,    B_DT,    WB_VY_SET, SEQ_NEXT);
            6'd25: c = cw(A_VX,    B_DT,    WB_W_SET,  SEQ_DONE);
            6'd26: c = cw(A_VX,    B_DT,    WB_NONE,   SEQ_NEXT);
            6'd27: c = cw(A_VY,    B_DT,    WB_NONE,   SEQ_NEXT);
            6'd28: c = cw(A_W,     B_DT,    WB_PX_ADD, SEQ_NEXT);
            6'd29: c = cw(A_VX,    B_DT,    WB_PY_ADD, SEQ_DONE_IF_SLOW);
            6'd30: c = cw(A_VX,    B_DT,    WB_ANG,    SEQ_NEXT);
            6'd31: c = cw(A_ANG,   B_DEG,   WB_NONE,   SEQ_NEXT);
            6'd32: c = cw(A_VX,    B_DT,    WB_NONE,   SEQ_NEXT);
            6'd33: c = cw(A_VX,    B_DT,    WB_HD_ADD, SEQ_DONE);
            6'd34: c = cw(A_VX,    B_DT,    WB_CLR,    SEQ_DONE);
            6'd35: c = cw(A_VX,    B_DT,    WB_LOAD,   SEQ_DONE);
            default: c = cw(A_VX,  B_DT,    WB_NONE,   SEQ_DONE);
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/rigid_body_2d_integrator.sv @@
`timescale 1ns / 1ps
// Top level: 2D rigid body integrator, microcoded over one shared multiplier.
// Each item runs its microcode program in ST_RUN (a blocked item skips it), then
//   waits in ST_DONE until the output register is free to take the result.
// One item at a time: in_stall is high outside ST_IDLE, and the next item is
//   taken in ST_IDLE, after the result is registered.
// Reset (rst_n low) clears the body state and loads the register defaults.
module rigid_body_2d_integrator
    import rbi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    in_item_t        item_reg;
    out_item_t       out_reg;
    logic            out_valid_reg;
    logic            load_item, load_out, run, item_live, movable, spin_slow;
    ctrl_t           ctrl;

    logic [CFG_DATA_W-1:0] inv_mass_reg, lin_damp_reg, ang_damp_reg;
    logic                  kinematic_reg;

    logic signed [31:0] force_x_reg, force_y_reg, torque_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg, spin_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, heading_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg, acc_w_reg;
    logic [27:0]        inertia_reg;
    logic [16:0]        lin_factor_reg, ang_factor_reg;
    logic signed [35:0] ang_reg;

    logic signed [35:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [67:0] prod_full;
    logic signed [63:0] prod_reg;
    logic signed [63:0] rnd_full;
    logic signed [47:0] rnd_reg;

    logic signed [31:0] add_base;
    logic signed [47:0] add_term;
    logic signed [48:0] sum_full;
    logic signed [31:0] sum_sat;
    logic signed [47:0] factor_full;
    logic [16:0]        factor;

    assign ctrl      = ucode(pc_reg);
    assign run       = (state_reg == ST_RUN);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign movable   = !kinematic_reg && (inv_mass_reg != '0);
    assign spin_slow = (spin_reg > -SPIN_MIN) && (spin_reg < SPIN_MIN);

    always_comb
    begin
        case (in_data.kind) inside
            KIND_FORCE, KIND_IMPULSE, KIND_INTEG_VEL:  item_live = movable;
            KIND_TORQUE, KIND_ANG_IMP, KIND_INTEG_POS: item_live = !kinematic_reg;
            default:                                   item_live = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        load_item  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    load_item  = 1'b1;
                    pc_next    = entry_pc(in_data.kind);
                    state_next = item_live ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                pc_next = pc_reg + 6'd1;
                if (ctrl.seq == SEQ_DONE || (ctrl.seq == SEQ_DONE_IF_SLOW && spin_slow))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= in_data;
        end
        if (load_out)
        begin
            out_reg <= '{vel_x: vel_x_reg, vel_y: vel_y_reg, spin_rate: spin_reg,
                         pos_x: pos_x_reg, pos_y: pos_y_reg, heading_deg: heading_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg  <= INV_MASS_RESET;
            kinematic_reg <= 1'b0;
            lin_damp_reg  <= '0;
            ang_damp_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INV_MASS:    inv_mass_reg  <= cfg_data;
                CFG_KINEMATIC:   kinematic_reg <= cfg_data[0];
                CFG_LIN_DAMPING: lin_damp_reg  <= cfg_data;
                CFG_ANG_DAMPING: ang_damp_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ctrl.a_sel)
            A_FX:    mul_a = {{4{force_x_reg[31]}}, force_x_reg};
            A_FY:    mul_a = {{4{force_y_reg[31]}}, force_y_reg};
            A_TQ:    mul_a = {{4{torque_reg[31]}}, torque_reg};
            A_VX:    mul_a = {{4{vel_x_reg[31]}}, vel_x_reg};
            A_VY:    mul_a = {{4{vel_y_reg[31]}}, vel_y_reg};
            A_W:     mul_a = {{4{spin_reg[31]}}, spin_reg};
            A_TX:    mul_a = {{4{acc_x_reg[31]}}, acc_x_reg};
            A_TY:    mul_a = {{4{acc_y_reg[31]}}, acc_y_reg};
            A_TW:    mul_a = {{4{acc_w_reg[31]}}, acc_w_reg};
            A_INA:   mul_a = {{4{item_reg.val_a[31]}}, item_reg.val_a};
            A_INB:   mul_a = {{4{item_reg.val_b[31]}}, item_reg.val_b};
            A_INVM:  mul_a = {5'd0, inv_mass_reg};
            A_LDAMP: mul_a = {5'd0, lin_damp_reg};
            A_ADAMP: mul_a = {5'd0, ang_damp_reg};
            A_ANG:   mul_a = ang_reg;
            default: mul_a = '0;
        endcase
        case (ctrl.b_sel)
            B_INVM:  mul_b = {1'b0, inv_mass_reg};
            B_II:    mul_b = {4'd0, inertia_reg};
            B_DT:    mul_b = {12'd0, item_reg.step_time};
            B_FL:    mul_b = {15'd0, lin_factor_reg};
            B_FA:    mul_b = {15'd0, ang_factor_reg};
            B_DEG:   mul_b = DEG_PER_RAD;
            B_RECIP: mul_b = RECIP_TEN;
            default: mul_b = '0;
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign rnd_full  = prod_reg + (prod_reg[63] ? 64'sd32767 : 64'sd32768);

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(prod_full[63:0]);
        rnd_reg  <= $signed(rnd_full[63:16]);
    end

    always_comb
    begin
        case (ctrl.wb) inside
            WB_FX_IN:  add_base = force_x_reg;
            WB_FY_IN:  add_base = force_y_reg;
            WB_TQ_IN:  add_base = torque_reg;
            WB_VX_ADD: add_base = vel_x_reg;
            WB_VY_ADD: add_base = vel_y_reg;
            WB_W_ADD:  add_base = spin_reg;
            WB_PX_ADD: add_base = pos_x_reg;
            WB_PY_ADD: add_base = pos_y_reg;
            WB_HD_ADD: add_base = heading_reg;
            default:   add_base = '0;
        endcase
        case (ctrl.wb) inside
            WB_FX_IN, WB_TQ_IN: add_term = {{16{item_reg.val_a[31]}}, item_reg.val_a};
            WB_FY_IN:           add_term = {{16{item_reg.val_b[31]}}, item_reg.val_b};
            default:            add_term = rnd_reg;
        endcase
        sum_full = {{17{add_base[31]}}, add_base} + {add_term[47], add_term};
        if (!sum_full[48] && (sum_full[47:31] != '0))
        begin
            sum_sat = 32'sh7FFF_FFFF;
        end
        else if (sum_full[48] && (sum_full[47:31] != '1))
        begin
            sum_sat = 32'sh8000_0000;
        end
        else
        begin
            sum_sat = sum_full[31:0];
        end
        factor_full = ONE_Q16 - rnd_reg;
        factor      = (rnd_reg > ONE_Q16) ? 17'd0 : factor_full[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_x_reg <= '0;
            force_y_reg <= '0;
            torque_reg  <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            spin_reg    <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end
        else if (run)
        begin
            case (ctrl.wb)
                WB_FX_IN:              force_x_reg <= sum_sat;
                WB_FY_IN:              force_y_reg <= sum_sat;
                WB_TQ_IN:              torque_reg  <= sum_sat;
                WB_VX_ADD, WB_VX_SET:  vel_x_reg   <= sum_sat;
                WB_VY_ADD, WB_VY_SET:  vel_y_reg   <= sum_sat;
                WB_W_ADD, WB_W_SET:    spin_reg    <= sum_sat;
                WB_PX_ADD:             pos_x_reg   <= sum_sat;
                WB_PY_ADD:             pos_y_reg   <= sum_sat;
                WB_HD_ADD:             heading_reg <= sum_sat;
                WB_CLR:
                begin
                    force_x_reg <= '0;
                    force_y_reg <= '0;
                    torque_reg  <= '0;
                end
                WB_LOAD:
                begin
                    pos_x_reg   <= item_reg.val_a;
                    pos_y_reg   <= item_reg.val_b;
                    heading_reg <= item_reg.val_c;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            case (ctrl.wb)
                WB_TX_SET: acc_x_reg      <= sum_sat;
                WB_TY_SET: acc_y_reg      <= sum_sat;
                WB_TW_SET: acc_w_reg      <= sum_sat;
                WB_FL:     lin_factor_reg <= factor;
                WB_FA:     ang_factor_reg <= factor;
                WB_ANG:    ang_reg        <= rnd_reg[35:0];
                WB_II:     inertia_reg    <= prod_reg[61:34];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/rbi_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the rigid body integrator, bound to the top level.
module rbi_checker
    import rbi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // hold off the next item once one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in work");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

endmodule

bind rigid_body_2d_integrator rbi_checker u_rbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ bench/rigid_body_2d_integrator_check.sv @@
`timescale 1ns / 1ps
// Checker for the 2D rigid body integrator: predicts the motion state after each item and compares.
module rigid_body_2d_integrator_check
    import rbi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fails,
    output int                    pending
);

    localparam longint INERTIA_DIV = 10;
    localparam longint MAX32       = 64'sd2147483647;
    localparam longint MIN32       = -64'sd2147483648;
    localparam int     PRINT_CAP   = 100;

    logic [CFG_DATA_W-1:0] mass_q;
    logic                  kin_q;
    logic [CFG_DATA_W-1:0] lin_damp_q;
    logic [CFG_DATA_W-1:0] ang_damp_q;

    logic signed [31:0] body_fx;
    logic signed [31:0] body_fy;
    logic signed [31:0] body_tq;
    logic signed [31:0] body_vx;
    logic signed [31:0] body_vy;
    logic signed [31:0] body_spin;
    logic signed [31:0] body_px;
    logic signed [31:0] body_py;
    logic signed [31:0] body_head;

    out_item_t motion_q[$];
    int        result_count;

    function automatic longint round_q16(input longint p);
        if (p >= 0)
            return (p + 32768) >>> 16;
        return -((-p + 32768) >>> 16);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > MAX32)
            return 32'sh7fffffff;
        if (v < MIN32)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] damp_q16(input logic signed [31:0] v,
                                                     input logic [CFG_DATA_W-1:0] rate,
                                                     input logic [19:0] dt);
        longint f;
        f = longint'(ONE_Q16) - round_q16(longint'(rate) * longint'(dt));
        if (f < 0)
            f = 0;
        return clamp32(round_q16(longint'(v) * f));
    endfunction

    task automatic advance_body(input in_item_t ev, output out_item_t res);
        longint             a;
        longint             b;
        longint             im;
        longint             ii;
        longint             dt;
        longint             w;
        longint             ang;
        logic signed [31:0] acc;
        logic               movable;
        a       = longint'($signed(ev.val_a));
        b       = longint'($signed(ev.val_b));
        im      = longint'(mass_q);
        ii      = im / INERTIA_DIV;
        dt      = longint'(ev.step_time);
        movable = !kin_q && (mass_q != '0);
        case (ev.kind)
            KIND_FORCE:
                if (movable)
                begin
                    body_fx = clamp32(longint'(body_fx) + a);
                    body_fy = clamp32(longint'(body_fy) + b);
                end
            KIND_IMPULSE:
                if (movable)
                begin
                    body_vx = clamp32(longint'(body_vx) + round_q16(a * im));
                    body_vy = clamp32(longint'(body_vy) + round_q16(b * im));
                end
            KIND_TORQUE:
                if (!kin_q)
                    body_tq = clamp32(longint'(body_tq) + a);
            KIND_ANG_IMP:
                if (!kin_q)
                    body_spin = clamp32(longint'(body_spin) + round_q16(a * ii));
            KIND_INTEG_VEL:
                if (movable)
                begin
                    acc     = clamp32(round_q16(longint'(body_fx) * im));
                    body_vx = clamp32(longint'(body_vx) + round_q16(longint'(acc) * dt));
                    body_vx = damp_q16(body_vx, lin_damp_q, ev.step_time);
                    acc     = clamp32(round_q16(longint'(body_fy) * im));
                    body_vy = clamp32(longint'(body_vy) + round_q16(longint'(acc) * dt));
                    body_vy = damp_q16(body_vy, lin_damp_q, ev.step_time);
                    acc       = clamp32(round_q16(longint'(body_tq) * ii));
                    body_spin = clamp32(longint'(body_spin) + round_q16(longint'(acc) * dt));
                    body_spin = damp_q16(body_spin, ang_damp_q, ev.step_time);
                end
            KIND_INTEG_POS:
                if (!kin_q)
                begin
                    w       = longint'(body_spin);
                    body_px = clamp32(longint'(body_px) + round_q16(longint'(body_vx) * dt));
                    body_py = clamp32(longint'(body_py) + round_q16(longint'(body_vy) * dt));
                    if (w >= longint'(SPIN_MIN) || w <= -longint'(SPIN_MIN))
                    begin
                        ang       = round_q16(w * dt);
                        body_head = clamp32(longint'(body_head)
                                            + round_q16(ang * longint'(DEG_PER_RAD)));
                    end
                end
            KIND_CLEAR:
            begin
                body_fx = '0;
                body_fy = '0;
                body_tq = '0;
            end
            default:
            begin
                body_px   = ev.val_a;
                body_py   = ev.val_b;
                body_head = ev.val_c;
            end
        endcase
        res = '{vel_x: body_vx, vel_y: body_vy, spin_rate: body_spin,
                pos_x: body_px, pos_y: body_py, heading_deg: body_head};
    endtask

    task automatic note_miss(input string what, input logic [31:0] got,
                             input logic [31:0] want);
        if (fails < PRINT_CAP)
            $display("result %0d %s: got %h, want %h", result_count, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            mass_q       = INV_MASS_RESET;
            kin_q        = 1'b0;
            lin_damp_q   = '0;
            ang_damp_q   = '0;
            body_fx      = '0;
            body_fy      = '0;
            body_tq      = '0;
            body_vx      = '0;
            body_vy      = '0;
            body_spin    = '0;
            body_px      = '0;
            body_py      = '0;
            body_head    = '0;
            result_count = 0;
            fails        = 0;
            motion_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_INV_MASS:    mass_q     = cfg_data;
                    CFG_KINEMATIC:   kin_q      = cfg_data[0];
                    CFG_LIN_DAMPING: lin_damp_q = cfg_data;
                    default:         ang_damp_q = cfg_data;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_body(in_data, want);
                motion_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (motion_q.size() == 0)
                    note_miss("result with no item pending", out_data.vel_x, '0);
                else
                begin
                    want = motion_q.pop_front();
                    if (out_data.vel_x !== want.vel_x)
                        note_miss("vel_x", out_data.vel_x, want.vel_x);
                    if (out_data.vel_y !== want.vel_y)
                        note_miss("vel_y", out_data.vel_y, want.vel_y);
                    if (out_data.spin_rate !== want.spin_rate)
                        note_miss("spin_rate", out_data.spin_rate, want.spin_rate);
                    if (out_data.pos_x !== want.pos_x)
                        note_miss("pos_x", out_data.pos_x, want.pos_x);
                    if (out_data.pos_y !== want.pos_y)
                        note_miss("pos_y", out_data.pos_y, want.pos_y);
                    if (out_data.heading_deg !== want.heading_deg)
                        note_miss("heading_deg", out_data.heading_deg, want.heading_deg);
                end
                result_count++;
            end
            pending <= motion_q.size();
        end
    end

endmodule

@@ bench/rigid_body_2d_integrator_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the 2D rigid body integrator: clock, reset, stimulus and verdict.
module rigid_body_2d_integrator_test;
    import rbi_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int PHASE_COUNT      = 7;
    localparam int ITEMS_PER_PHASE  = 135;
    localparam int IDLE_PERCENT     = 38;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    in_item_t              in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    out_item_t             out_data;
    int                    fails;
    int                    pending;
    logic                  calm      = 1'b0;
    int                    cycles    = 0;

    always #5 clk = ~clk;

    rigid_body_2d_integrator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rigid_body_2d_integrator_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic in_item_t make_event(input logic [2:0] kind,
                                            input logic signed [31:0] a,
                                            input logic signed [31:0] b,
                                            input logic signed [31:0] c,
                                            input logic [19:0] dt);
        in_item_t ev;
        ev.kind      = kind;
        ev.val_a     = a;
        ev.val_b     = b;
        ev.val_c     = c;
        ev.step_time = dt;
        return ev;
    endfunction

    function automatic logic signed [31:0] pick_q16();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7fffffff;
            1:       v = 32'sh80000000;
            2, 3:    v = $urandom;
            4:       v = '0;
            default:
            begin
                v = $urandom_range(0, 524288);
                v = v - 32'sd262144;
            end
        endcase
        return v;
    endfunction

    function automatic logic [19:0] pick_step();
        logic [19:0] dt;
        case ($urandom_range(0, 9))
            0:       dt = 20'hfffff;
            1:       dt = '0;
            2:       dt = 20'($urandom);
            default: dt = 20'($urandom_range(0, 65536));
        endcase
        return dt;
    endfunction

    function automatic in_item_t random_event();
        int          r;
        logic [2:0]  kind;
        r = $urandom_range(0, 99);
        if (r < 15)
            kind = KIND_FORCE;
        else if (r < 27)
            kind = KIND_IMPULSE;
        else if (r < 39)
            kind = KIND_TORQUE;
        else if (r < 51)
            kind = KIND_ANG_IMP;
        else if (r < 67)
            kind = KIND_INTEG_VEL;
        else if (r < 83)
            kind = KIND_INTEG_POS;
        else if (r < 90)
            kind = KIND_CLEAR;
        else
            kind = KIND_LOAD_POSE;
        return make_event(kind, pick_q16(), pick_q16(), pick_q16(), pick_step());
    endfunction

    task automatic send_event(input in_item_t ev);
        while (!calm && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setup(input logic [CFG_DATA_W-1:0] mass,
                               input logic [CFG_DATA_W-1:0] kin,
                               input logic [CFG_DATA_W-1:0] lin,
                               input logic [CFG_DATA_W-1:0] ang);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_INV_MASS;
        cfg_data  <= mass;
        @(posedge clk);
        cfg_index <= CFG_KINEMATIC;
        cfg_data  <= kin;
        @(posedge clk);
        cfg_index <= CFG_LIN_DAMPING;
        cfg_data  <= lin;
        @(posedge clk);
        cfg_index <= CFG_ANG_DAMPING;
        cfg_data  <= ang;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic signed [31:0]    top_v;
        logic signed [31:0]    low_v;
        logic [CFG_DATA_W-1:0] mass;
        logic [CFG_DATA_W-1:0] kin;
        logic [CFG_DATA_W-1:0] lin;
        logic [CFG_DATA_W-1:0] ang;
        int                    p;
        int                    n;
        top_v = 32'sh7fffffff;
        low_v = 32'sh80000000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setup(31'd65536, '0, '0, '0);
        // walk the spin across the heading threshold
        send_event(make_event(KIND_ANG_IMP, 32'sd60, 32'sd5, 32'sd9, 20'd3));
        send_event(make_event(KIND_INTEG_POS, 32'sd1, 32'sd2, 32'sd3, 20'h10000));
        send_event(make_event(KIND_ANG_IMP, 32'sd10, low_v, top_v, 20'hfffff));
        send_event(make_event(KIND_INTEG_POS, 32'sd0, 32'sd0, 32'sd0, 20'h10000));
        send_event(make_event(KIND_FORCE, top_v, low_v, 32'sd7, 20'hfffff));
        send_event(make_event(KIND_FORCE, 32'sd1, -32'sd1, low_v, 20'd0));
        send_event(make_event(KIND_INTEG_VEL, 32'sd0, 32'sd0, 32'sd0, 20'hfffff));
        send_event(make_event(KIND_INTEG_POS, top_v, top_v, top_v, 20'hfffff));
        send_event(make_event(KIND_IMPULSE, low_v, top_v, 32'sd0, 20'h12345));
        send_event(make_event(KIND_TORQUE, top_v, low_v, low_v, 20'd0));
        send_event(make_event(KIND_TORQUE, 32'sd1, 32'sd0, 32'sd0, 20'd0));
        send_event(make_event(KIND_INTEG_VEL, 32'sd0, 32'sd0, 32'sd0, 20'd0));
        send_event(make_event(KIND_CLEAR, top_v, top_v, top_v, 20'hfffff));
        send_event(make_event(KIND_LOAD_POSE, low_v, top_v, top_v, 20'hfffff));

        apply_setup(31'd65536, 31'd1, '0, '0);
        send_event(make_event(KIND_FORCE, 32'sd65536, 32'sd65536, 32'sd0, 20'd0));
        send_event(make_event(KIND_ANG_IMP, 32'sd65536, 32'sd0, 32'sd0, 20'd0));
        send_event(make_event(KIND_INTEG_VEL, 32'sd0, 32'sd0, 32'sd0, 20'h10000));
        send_event(make_event(KIND_INTEG_POS, 32'sd0, 32'sd0, 32'sd0, 20'h10000));

        apply_setup('0, '0, 31'd65536, 31'd65536);
        send_event(make_event(KIND_IMPULSE, 32'sd65536, -32'sd65536, 32'sd0, 20'd0));
        send_event(make_event(KIND_ANG_IMP, top_v, 32'sd0, 32'sd0, 20'd0));
        send_event(make_event(KIND_INTEG_VEL, 32'sd0, 32'sd0, 32'sd0, 20'h8000));
        send_event(make_event(KIND_INTEG_POS, 32'sd0, 32'sd0, 32'sd0, 20'h8000));

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    mass = 31'd65536;
                    kin  = '0;
                    lin  = '0;
                    ang  = '0;
                end
                1:
                begin
                    mass = CFG_DATA_W'($urandom_range(1, 1 << 20));
                    kin  = '0;
                    lin  = CFG_DATA_W'($urandom_range(0, 1 << 17));
                    ang  = CFG_DATA_W'($urandom_range(0, 1 << 17));
                end
                2:
                begin
                    mass = '0;
                    kin  = CFG_DATA_W'($urandom);
                    kin[0] = 1'b0;
                    lin  = CFG_DATA_W'($urandom);
                    ang  = CFG_DATA_W'($urandom);
                end
                3:
                begin
                    mass = CFG_DATA_W'($urandom);
                    kin  = CFG_DATA_W'($urandom);
                    kin[0] = 1'b1;
                    lin  = CFG_DATA_W'($urandom_range(0, 1 << 16));
                    ang  = CFG_DATA_W'($urandom_range(0, 1 << 16));
                end
                4:
                begin
                    mass = 31'h7fffffff;
                    kin  = '0;
                    lin  = 31'h7fffffff;
                    ang  = 31'h7fffffff;
                end
                5:
                begin
                    mass = 31'd1;
                    kin  = '0;
                    lin  = 31'd1;
                    ang  = '0;
                end
                default:
                begin
                    mass = CFG_DATA_W'($urandom);
                    kin  = CFG_DATA_W'($urandom);
                    lin  = CFG_DATA_W'($urandom);
                    ang  = CFG_DATA_W'($urandom);
                end
            endcase
            apply_setup(mass, kin, lin, ang);
            calm = (p == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_event(random_event());
            calm = 1'b0;
        end

        settle();
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rbi_pkg.sv
rtl/core/rigid_body_2d_integrator.sv
rtl/core/rbi_checker.sv
bench/rigid_body_2d_integrator_check.sv
bench/rigid_body_2d_integrator_test.sv
